// File: sv/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
// Used by sha1_sched, sha1_round and sha1_hash_engine; depends on nothing.
package sha1_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned Rounds = 80;

  localparam logic [WordW-1:0] IV [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [WordW-1:0] K [4] = '{
    32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [WordW-1:0] PAD_WORD = {PAD_MARK, 24'h00_0000};

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    logic [WordW-1:0] e;
  } work_t;

  typedef struct packed {
    logic             push;
    logic             step;
    logic [WordW-1:0] data;
  } sched_cmd_t;

endpackage

// File: sv/sha1_sched.sv
// Rolling 16-word message schedule held as a shift line with fixed taps.
// Depends on sha1_pkg for the command struct.
module sha1_sched (
  input  logic                            clk,
  input  sha1_pkg::sched_cmd_t            cmd,
  output logic [sha1_pkg::WordW-1:0]      w_cur
);
  import sha1_pkg::*;

  logic [WordW-1:0] sr [16];
  logic [WordW-1:0] mix;
  logic [WordW-1:0] shift_in;

  assign mix = sr[13] ^ sr[8] ^ sr[2] ^ sr[0];
  assign shift_in = cmd.push ? cmd.data : {mix[WordW-2:0], mix[WordW-1]};
  assign w_cur = sr[0];

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.step) begin
      for (int i = 0; i < 15; i++) begin
        sr[i] <= sr[i+1];
      end
      sr[15] <= shift_in;
    end
  end

endmodule

// File: sv/sha1_round.sv
// One SHA-1 compression round, shared across all 80 rounds of a block.
// Depends on sha1_pkg for the working-variable struct and round constants.
module sha1_round (
  input  sha1_pkg::work_t                 cur,
  input  logic [sha1_pkg::WordW-1:0]      w,
  input  logic [6:0]                      rnd,
  output sha1_pkg::work_t                 nxt
);
  import sha1_pkg::*;

  logic [WordW-1:0] f;
  logic [WordW-1:0] k;
  logic [WordW-1:0] rot_a;

  always_comb begin
    priority if (rnd < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = K[0];
    end else if (rnd < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K[1];
    end else if (rnd < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = K[2];
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = K[3];
    end
  end

  assign rot_a = {cur.a[26:0], cur.a[31:27]};

  always_comb begin
    nxt.a = rot_a + f + cur.e + k + w;
    nxt.b = cur.a;
    nxt.c = {cur.b[1:0], cur.b[31:2]};
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule

// File: sv/sha1_hash_engine.sv
// SHA-1 hash engine top level: sequencer, length counter, hash state and outputs.
// Depends on sha1_pkg, sha1_sched and sha1_round.
//
// Message words are taken one per cycle while the engine is idle; every sixteenth word
// starts a compression run of 80 rounds through the single round unit, during which no
// word is accepted. The final word starts padding, which pushes one word per cycle (up
// to 18, one extra block of 80 rounds when the length does not fit), and then the five
// digest words H0 to H4 are offered one per transfer before the engine clears itself
// for the next message.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] message_word,
  input  logic [2:0]  valid_bytes,
  input  logic        final_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_done
);
  import sha1_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PAD   = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [3:0]       wcount;
  logic [6:0]       rnd;
  logic             pend80, lenhi_done, last_blk, padding;
  logic [2:0]       out_idx;
  logic [63:0]      bit_len;
  logic [WordW-1:0] hash [5];
  work_t            work, work_next;
  logic [WordW-1:0] w_cur;
  sched_cmd_t       cmd;
  logic [2:0]       nv;
  logic [WordW-1:0] first_pad;
  logic             in_xfer, out_xfer;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (state == ST_OUT);
  assign out_xfer  = out_valid && out_ready;

  assign digest_word = hash[out_idx];
  assign word_index  = out_idx;
  assign digest_done = (out_idx == 3'd4);

  assign nv = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

  always_comb begin
    unique case (nv)
      3'd0:    first_pad = PAD_WORD;
      3'd1:    first_pad = {message_word[31:24], PAD_MARK, 16'h0000};
      3'd2:    first_pad = {message_word[31:16], PAD_MARK, 8'h00};
      3'd3:    first_pad = {message_word[31:8], PAD_MARK};
      default: first_pad = message_word;
    endcase
  end

  always_comb begin
    cmd.push = 1'b0;
    cmd.step = (state == ST_ROUND);
    cmd.data = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.push = in_valid;
        cmd.data = final_word ? first_pad : message_word;
      end
      ST_PAD: begin
        cmd.push = 1'b1;
        priority if (pend80) begin
          cmd.data = PAD_WORD;
        end else if (wcount == 4'd14) begin
          cmd.data = bit_len[63:32];
        end else if (wcount == 4'd15 && lenhi_done) begin
          cmd.data = bit_len[31:0];
        end else begin
          cmd.data = '0;
        end
      end
      default: begin
        cmd.push = 1'b0;
      end
    endcase
  end

  sha1_sched u_sched (
    .clk   (clk),
    .cmd   (cmd),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .cur (work),
    .w   (w_cur),
    .rnd (rnd),
    .nxt (work_next)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (wcount == 4'd15) begin
            state_next = ST_ROUND;
          end else if (final_word) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (wcount == 4'd15) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 7'(Rounds - 1)) begin
          priority if (last_blk) begin
            state_next = ST_OUT;
          end else if (padding) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (out_xfer && out_idx == 3'd4) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wcount     <= '0;
      rnd        <= '0;
      pend80     <= 1'b0;
      lenhi_done <= 1'b0;
      last_blk   <= 1'b0;
      padding    <= 1'b0;
      out_idx    <= '0;
      bit_len    <= '0;
      work       <= '0;
      for (int i = 0; i < 5; i++) begin
        hash[i] <= IV[i];
      end
    end else begin
      state <= state_next;

      if (cmd.push) begin
        wcount <= wcount + 4'd1;
        if (wcount == 4'd15) begin
          rnd  <= '0;
          work <= '{a: hash[0], b: hash[1], c: hash[2], d: hash[3], e: hash[4]};
        end
      end

      if (in_xfer) begin
        if (final_word) begin
          bit_len <= bit_len + {58'd0, nv, 3'd0};
          padding <= 1'b1;
          pend80  <= (nv == 3'd4);
        end else begin
          bit_len <= bit_len + 64'd32;
        end
      end

      if (state == ST_PAD) begin
        priority if (pend80) begin
          pend80 <= 1'b0;
        end else if (wcount == 4'd14) begin
          lenhi_done <= 1'b1;
        end else if (wcount == 4'd15 && lenhi_done) begin
          last_blk <= 1'b1;
        end else begin
          last_blk <= last_blk;
        end
      end

      if (state == ST_ROUND) begin
        work <= work_next;
        rnd  <= rnd + 7'd1;
        if (rnd == 7'(Rounds - 1)) begin
          hash[0] <= hash[0] + work_next.a;
          hash[1] <= hash[1] + work_next.b;
          hash[2] <= hash[2] + work_next.c;
          hash[3] <= hash[3] + work_next.d;
          hash[4] <= hash[4] + work_next.e;
        end
      end

      if (out_xfer) begin
        if (out_idx == 3'd4) begin
          out_idx    <= '0;
          bit_len    <= '0;
          wcount     <= '0;
          pend80     <= 1'b0;
          lenhi_done <= 1'b0;
          last_blk   <= 1'b0;
          padding    <= 1'b0;
          rnd        <= '0;
          work       <= '0;
          for (int i = 0; i < 5; i++) begin
            hash[i] <= IV[i];
          end
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

endmodule
